[hdl/mf5_pkg.sv]
`timescale 1ns / 1ps
package mf5_pkg;
  localparam int MaxWidth  = 2048;
  localparam int Window    = 5;
  localparam int PixBits   = 8;
  localparam int WinCells  = Window * Window;
  localparam int StoreLines = Window - 1;
  localparam int ColBits   = $clog2(MaxWidth);
  localparam int RowBits   = 16;
  localparam int MedRank   = WinCells / 2;
  localparam int CntBits   = $clog2(WinCells + 1);

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef logic [PixBits-1:0] pix_t;

  typedef struct packed {
    logic [ColBits-1:0] col;
    logic [RowBits-1:0] row;
    logic               last;
  } tag_t;
endpackage

[hdl/mf5_rank_cell.sv]
`timescale 1ns / 1ps
// one stage of the rank chain: folds one window value into a running count
// of values strictly below and equal-or-below the candidate
module mf5_rank_cell (
  input  logic                  clk,
  input  logic                  en,
  input  mf5_pkg::pix_t         cand,
  input  logic [mf5_pkg::CntBits-1:0] lt_in,
  input  logic [mf5_pkg::CntBits-1:0] le_in,
  input  mf5_pkg::pix_t         other,
  output mf5_pkg::pix_t         cand_out,
  output logic [mf5_pkg::CntBits-1:0] lt_out,
  output logic [mf5_pkg::CntBits-1:0] le_out
);
  import mf5_pkg::*;
  always_ff @(posedge clk) begin
    if (en) begin
      cand_out <= cand;
      lt_out   <= lt_in + CntBits'(other < cand);
      le_out   <= le_in + CntBits'(other <= cand);
    end
  end
endmodule

[hdl/mf5_line_store.sv]
`timescale 1ns / 1ps
// one delay line of the line store, separate write and read ports,
// registered read
module mf5_line_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [mf5_pkg::ColBits-1:0] waddr,
  input  mf5_pkg::pix_t              wdata,
  input  logic                       re,
  input  logic [mf5_pkg::ColBits-1:0] raddr,
  output mf5_pkg::pix_t              rdata
);
  import mf5_pkg::*;
  pix_t mem [MaxWidth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

[hdl/median_filter_5x5.sv]
`timescale 1ns / 1ps
// 5x5 median filter for 8-bit grayscale pixels in raster order. one pixel is
// taken per clock while the output side keeps up. after the pixel that
// completes its window is taken, its median passes the line-store read, the
// window update, a chain of 25 rank cells for each of the 25 window values
// and then the output register. border pixels give no request on the output.
// the four stored lines sit in four memories of 2048 pixels, each with one
// write port and one read port, read at the current column and written back
// at that column in the next cycle. the pipeline advances only when its
// output register is free or being taken, so a stall downstream holds the
// whole chain and drops nothing. width and height are to be written only
// while the block is idle; the block itself does not enforce this.
module median_filter_5x5 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  logic [7:0]  pixel,
  output logic        median_valid,
  input  logic        median_ready,
  output logic [7:0]  median_value,
  output logic [10:0] centre_col,
  output logic [15:0] centre_row,
  output logic        frame_last
);
  import mf5_pkg::*;

  localparam int Depth = WinCells + 2;

  logic [11:0] image_width;
  logic [15:0] image_height;
  logic [12:0] w_eff;
  logic [15:0] h_eff;
  logic [ColBits:0]  column_count;
  logic [RowBits-1:0] row_count;
  logic [ColBits:0]  col_now;
  logic [RowBits-1:0] row_now;

  logic adv;
  logic take;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd512;
      image_height <= 16'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        RegWidth:  image_width  <= cfg_data[11:0];
        RegHeight: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = {1'b0, image_width};
    if (w_eff > 13'(MaxWidth)) w_eff = 13'(MaxWidth);
    if (w_eff < 13'(Window))   w_eff = 13'(Window);
    h_eff = (image_height < 16'(Window)) ? 16'(Window) : image_height;
  end

  // pipeline valid bits: stage 0 is the line-store read, stage 1 the window
  logic [Depth-1:0] vld;
  logic out_full;
  assign adv = !out_full || median_ready;
  assign pixel_ready = adv;
  assign take = pixel_valid && adv;

  // position counters, wrapped at the current limits
  always_comb begin
    col_now = (13'(column_count) >= w_eff) ? '0 : column_count;
    row_now = (row_count >= h_eff) ? '0 : row_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      if (13'(col_now) + 13'd1 >= w_eff) begin
        column_count <= '0;
        row_count    <= (17'(row_now) + 17'd1 >= 17'(h_eff)) ? '0 : row_now + 1'b1;
      end else begin
        column_count <= col_now + 1'b1;
      end
    end
  end

  // line store: four lines, each a memory
  pix_t ls_q [StoreLines];
  pix_t px_d;
  tag_t tag_d;
  logic emit_d;
  logic [ColBits-1:0] addr;
  assign addr = col_now[ColBits-1:0];

  // line r is written with line r+1 read now, the top line with the new pixel;
  // the ram reads old data, so write back next cycle from the registered reads
  logic [ColBits-1:0] addr_d;
  logic               wb;
  for (genvar r = 0; r < StoreLines; r++) begin : g_ls
    pix_t wd;
    if (r == StoreLines - 1) begin : g_top
      assign wd = px_d;
    end else begin : g_mid
      assign wd = ls_q[r+1];
    end
    // a read and the delayed write of the same column never collide, as the
    // next pixel is always at another column (width is at least five)
    mf5_line_store u_ls (
      .clk   (clk),
      .we    (wb),
      .waddr (addr_d),
      .wdata (wd),
      .re    (take),
      .raddr (addr),
      .rdata (ls_q[r])
    );
  end

  // write-back goes through its own port, so a new read can share the cycle
  always_ff @(posedge clk) begin
    if (rst) wb <= 1'b0;
    else     wb <= take;
    if (take) begin
      px_d   <= pixel;
      addr_d <= addr;
      tag_d.col  <= ColBits'(col_now - 13'(Window / 2));
      tag_d.row  <= RowBits'(row_now - 16'(Window / 2));
      tag_d.last <= (row_now == h_eff - 1'b1) && (13'(col_now) == w_eff - 1'b1);
      emit_d <= (row_now >= 16'(Window - 1)) && (col_now >= 12'(Window - 1));
    end
  end

  // window shift
  pix_t win [Window][Window];
  tag_t tag_w;
  logic emit_w;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < Window; r++)
        for (int c = 0; c < Window; c++) win[r][c] <= '0;
    end else if (adv && vld[0]) begin
      for (int r = 0; r < Window; r++)
        for (int c = 0; c < Window - 1; c++) win[r][c] <= win[r][c+1];
      for (int r = 0; r < StoreLines; r++) win[r][Window-1] <= ls_q[r];
      win[Window-1][Window-1] <= px_d;
    end
    if (adv && vld[0]) begin
      tag_w  <= tag_d;
      emit_w <= emit_d;
    end
  end

  // rank chain: each window value carried with its counts through 25 cells
  pix_t snap [WinCells];
  pix_t cand [WinCells][WinCells+1];
  logic [CntBits-1:0] lt [WinCells][WinCells+1];
  logic [CntBits-1:0] le [WinCells][WinCells+1];
  tag_t tag_p [WinCells];
  logic emit_p [WinCells];

  always_comb begin
    for (int r = 0; r < Window; r++)
      for (int c = 0; c < Window; c++) snap[r*Window+c] = win[r][c];
  end

  // copies of the window travel with the chain, one stage per cell
  pix_t wcopy [WinCells][WinCells];
  always_comb for (int k = 0; k < WinCells; k++) wcopy[0][k] = snap[k];

  for (genvar s = 0; s < WinCells; s++) begin : g_stage
    if (s < WinCells - 1) begin : g_copy
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int k = 0; k < WinCells; k++) wcopy[s+1][k] <= wcopy[s][k];
        end
      end
    end
    if (s == 0) begin : g_tag_first
      always_ff @(posedge clk) begin
        if (adv) begin
          tag_p[0]  <= tag_w;
          emit_p[0] <= emit_w;
        end
      end
    end else begin : g_tag_next
      always_ff @(posedge clk) begin
        if (adv) begin
          tag_p[s]  <= tag_p[s-1];
          emit_p[s] <= emit_p[s-1];
        end
      end
    end
    for (genvar k = 0; k < WinCells; k++) begin : g_cell
      pix_t co;
      logic [CntBits-1:0] lo, eo;
      if (s == 0) begin : g_first
        assign cand[k][0] = snap[k];
        assign lt[k][0] = '0;
        assign le[k][0] = '0;
      end
      mf5_rank_cell u_cell (
        .clk      (clk),
        .en       (adv),
        .cand     (cand[k][s]),
        .lt_in    (lt[k][s]),
        .le_in    (le[k][s]),
        .other    (wcopy[s][s]),
        .cand_out (co),
        .lt_out   (lo),
        .le_out   (eo)
      );
      assign cand[k][s+1] = co;
      assign lt[k][s+1] = lo;
      assign le[k][s+1] = eo;
    end
  end

  // pick the value whose rank interval covers the middle rank
  pix_t med;
  always_comb begin
    med = '0;
    for (int k = 0; k < WinCells; k++)
      if (lt[k][WinCells] <= CntBits'(MedRank) && le[k][WinCells] > CntBits'(MedRank))
        med = cand[k][WinCells];
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Depth-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (adv) out_full <= vld[Depth-1] && emit_p[WinCells-1];
    if (adv) begin
      median_value <= med;
      centre_col   <= tag_p[WinCells-1].col;
      centre_row   <= tag_p[WinCells-1].row;
      frame_last   <= tag_p[WinCells-1].last;
    end
  end
  assign median_valid = out_full;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    median_valid && !median_ready |=> median_valid && $stable(median_value))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !median_valid |-> pixel_ready) else $error("ready low with empty output");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    13'(column_count) <= w_eff || $past(cfg_we)) else $error("column count past width");
endmodule
